// ----- rtl/core/frame_time_smoother_core_assert.svh -----
// Assertion macros shared by the frame time smoother checkers.
// Both macros sample on the rising edge of clk and stay quiet while arst_n is low.
`ifndef FRAME_TIME_SMOOTHER_CORE_ASSERT_SVH
`define FRAME_TIME_SMOOTHER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FTS_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("frame_time_smoother_core: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define FTS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("frame_time_smoother_core: next-cycle check failed");

`endif

// ----- rtl/core/fts_pkg.sv -----
// ----------------------------------------------------------------------------
// fts_pkg
// Shared widths, register codes, reset values and the control and status
// bundles that pass between the frame time smoother controller and datapath.
// ----------------------------------------------------------------------------
package fts_pkg;

	// Field widths
	localparam int unsigned PERIOD_W  = 24;
	localparam int unsigned ALPHA_W   = 9;
	localparam int unsigned SCALE_W   = 16;
	localparam int unsigned SMOOTH_W  = 32;
	localparam int unsigned SCALED_W  = 40;
	localparam int unsigned ELAPSED_W = 56;
	localparam int unsigned FPS_W     = 20;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DAT_W = 24;

	// Shared multiplier operand and product widths
	localparam int unsigned MUL_A_W = SMOOTH_W;
	localparam int unsigned MUL_B_W = SCALE_W;
	localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

	// Blend accumulator: two 41-bit products and their sum
	localparam int unsigned BLEND_W = 42;

	// Default tick rate of the frame rate divide
	localparam int unsigned TICKS_DEFAULT = 1000000;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PERIOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE      = 2'd2;

	// Register reset values
	localparam logic [PERIOD_W-1:0] MAX_PERIOD_RST = 24'd100000;
	localparam logic [ALPHA_W-1:0]  ALPHA_RST      = 9'd26;
	localparam logic [SCALE_W-1:0]  SCALE_RST      = 16'd256;

	// Unity weight in Q1.8
	localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

	// Frame rate ceiling
	localparam logic [FPS_W-1:0] FPS_MAX = 20'hFFFFF;

	// Shared multiplier operand selects
	localparam logic [1:0] MUL_OLD   = 2'd0;
	localparam logic [1:0] MUL_NEW   = 2'd1;
	localparam logic [1:0] MUL_SCALE = 2'd2;

	// Controller to datapath commands
	typedef struct packed {
		logic       load_in;
		logic [1:0] mul_sel;
		logic       acc_load;
		logic       smooth_upd;
		logic       accum;
		logic       out_load;
	} fts_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic div_done;
	} fts_sts_t;

endpackage

// ----- rtl/core/fts_div.sv -----
// ----------------------------------------------------------------------------
// fts_div
// Restoring divider, one quotient bit per cycle: a fixed dividend over a
// 24-bit divisor loaded at start. done rises when the last bit is in.
// ----------------------------------------------------------------------------
module fts_div
	import fts_pkg::*;
#(
	parameter int unsigned DIVIDEND = TICKS_DEFAULT,
	localparam int unsigned Q_W   = $clog2(DIVIDEND + 1),
	localparam int unsigned CNT_W = $clog2(Q_W + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [PERIOD_W-1:0] divisor,
	output logic [Q_W-1:0]      quotient,
	output logic                done
);

	localparam logic [Q_W-1:0]   DVD   = Q_W'(DIVIDEND);
	localparam logic [CNT_W-1:0] STEPS = CNT_W'(Q_W);

	logic [CNT_W-1:0]    cnt_q;
	logic                done_q;
	logic [Q_W-1:0]      dvd_q;
	logic [Q_W-1:0]      quo_q;
	logic [PERIOD_W-1:0] rem_q;
	logic [PERIOD_W-1:0] dsr_q;
	logic [PERIOD_W:0]   trial;
	logic                ge;

	// Bring down the next dividend bit and compare against the divisor
	assign trial = {rem_q, dvd_q[Q_W-1]};
	assign ge    = (trial >= {1'b0, dsr_q});

	// Step counter and completion flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= STEPS;
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				done_q <= 1'b1;
			end
		end
	end

	// Shift in one quotient bit per step
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= DVD;
			quo_q <= '0;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (cnt_q != '0) begin
			dvd_q <= dvd_q << 1;
			quo_q <= {quo_q[Q_W-2:0], ge};
			rem_q <= ge ? PERIOD_W'(trial - {1'b0, dsr_q}) : trial[PERIOD_W-1:0];
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

// ----- rtl/core/fts_dp.sv -----
// ----------------------------------------------------------------------------
// fts_dp
// Datapath: configuration registers, clamp, shared 32x16 multiplier, blend
// accumulator, smoothed and elapsed state, frame rate divider and the output
// holding registers.
// ----------------------------------------------------------------------------
module fts_dp
	import fts_pkg::*;
#(
	parameter int unsigned TICKS_PER_SECOND = TICKS_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	input  logic [PERIOD_W-1:0]  period_us,
	input  fts_cmd_t             cmd,
	output fts_sts_t             sts,
	output logic [PERIOD_W-1:0]  unscaled_delta_us,
	output logic [SCALED_W-1:0]  scaled_delta,
	output logic [ELAPSED_W-1:0] elapsed_total,
	output logic [FPS_W-1:0]     frames_per_second
);

	localparam int unsigned Q_W  = $clog2(TICKS_PER_SECOND + 1);
	localparam int unsigned QX_W = (Q_W > FPS_W) ? Q_W : FPS_W;

	logic [PERIOD_W-1:0]  max_period_q;
	logic [ALPHA_W-1:0]   alpha_cfg_q;
	logic [SCALE_W-1:0]   scale_q;
	logic [SMOOTH_W-1:0]  smooth_q;
	logic [ELAPSED_W-1:0] elapsed_q;
	logic [PERIOD_W-1:0]  raw_q;
	logic [BLEND_W-1:0]   acc_q;
	logic [SCALED_W-1:0]  scaled_q;
	logic [MUL_P_W-1:0]   prod_s1;
	logic [PERIOD_W-1:0]  raw_out_q;
	logic [SCALED_W-1:0]  scaled_out_q;
	logic [ELAPSED_W-1:0] elapsed_out_q;
	logic [FPS_W-1:0]     fps_out_q;

	logic [PERIOD_W-1:0]  clamped;
	logic [ALPHA_W-1:0]   alpha;
	logic [ALPHA_W-1:0]   keep_w;
	logic [MUL_A_W-1:0]   mul_a;
	logic [MUL_B_W-1:0]   mul_b;
	logic [BLEND_W-1:0]   blend_sum;
	logic [SMOOTH_W-1:0]  sample;
	logic [Q_W-1:0]       quotient;
	logic [QX_W-1:0]      quo_ext;
	logic [FPS_W-1:0]     fps;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_period_q <= MAX_PERIOD_RST;
			alpha_cfg_q  <= ALPHA_RST;
			scale_q      <= SCALE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MAX_PERIOD: max_period_q <= cfg_data;
				CFG_ALPHA:      alpha_cfg_q  <= cfg_data[ALPHA_W-1:0];
				CFG_SCALE:      scale_q      <= cfg_data[SCALE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Clamp the period and limit alpha to one
	assign clamped = (period_us > max_period_q) ? max_period_q : period_us;
	assign alpha   = (alpha_cfg_q > ALPHA_ONE) ? ALPHA_ONE : alpha_cfg_q;
	assign keep_w  = ALPHA_ONE - alpha;
	assign sample  = {raw_q, 8'd0};

	// Select operands of the shared multiplier
	always_comb begin
		case (cmd.mul_sel)
			MUL_OLD: begin
				mul_a = smooth_q;
				mul_b = MUL_B_W'(keep_w);
			end
			MUL_NEW: begin
				mul_a = sample;
				mul_b = MUL_B_W'(alpha);
			end
			MUL_SCALE: begin
				mul_a = smooth_q;
				mul_b = scale_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Register the product
	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
	end

	// Hold the clamped period, the first blend term and the scaled delta
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			raw_q <= clamped;
		end
		if (cmd.acc_load) begin
			acc_q <= prod_s1[BLEND_W-1:0];
		end
		if (cmd.accum) begin
			scaled_q <= prod_s1[MUL_P_W-1:8];
		end
	end

	assign blend_sum = acc_q + prod_s1[BLEND_W-1:0];

	// Smoothed period and elapsed accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_q  <= '0;
			elapsed_q <= '0;
		end else begin
			if (cmd.smooth_upd) begin
				smooth_q <= (smooth_q == '0) ? sample : blend_sum[SMOOTH_W+7:8];
			end
			if (cmd.accum) begin
				elapsed_q <= elapsed_q + ELAPSED_W'(prod_s1[MUL_P_W-1:8]);
			end
		end
	end

	// Frame rate divider
	fts_div #(
		.DIVIDEND (TICKS_PER_SECOND)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.load_in),
		.divisor  (clamped),
		.quotient (quotient),
		.done     (sts.div_done)
	);

	// Saturate the rate and force zero for a zero period
	assign quo_ext = QX_W'(quotient);
	always_comb begin
		if (raw_q == '0) begin
			fps = '0;
		end else if (quo_ext > QX_W'(FPS_MAX)) begin
			fps = FPS_MAX;
		end else begin
			fps = quo_ext[FPS_W-1:0];
		end
	end

	// Output holding registers
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			raw_out_q     <= raw_q;
			scaled_out_q  <= scaled_q;
			elapsed_out_q <= elapsed_q;
			fps_out_q     <= fps;
		end
	end

	assign unscaled_delta_us = raw_out_q;
	assign scaled_delta      = scaled_out_q;
	assign elapsed_total     = elapsed_out_q;
	assign frames_per_second = fps_out_q;

endmodule

// ----- rtl/core/fts_ctrl.sv -----
// ----------------------------------------------------------------------------
// fts_ctrl
// Controller: steps the datapath through the multiply sequence for one item,
// waits for the divider and owns both channel handshakes.
// ----------------------------------------------------------------------------
module fts_ctrl
	import fts_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  fts_sts_t sts,
	output fts_cmd_t cmd
);

	localparam logic [2:0] S_IDLE      = 3'd0;
	localparam logic [2:0] S_MUL_OLD   = 3'd1;
	localparam logic [2:0] S_MUL_NEW   = 3'd2;
	localparam logic [2:0] S_BLEND     = 3'd3;
	localparam logic [2:0] S_MUL_SCALE = 3'd4;
	localparam logic [2:0] S_ACCUM     = 3'd5;
	localparam logic [2:0] S_FINISH    = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_MUL_OLD;
				end
			end
			S_MUL_OLD: begin
				cmd.mul_sel = MUL_OLD;
				state_d     = S_MUL_NEW;
			end
			S_MUL_NEW: begin
				cmd.mul_sel  = MUL_NEW;
				cmd.acc_load = 1'b1;
				state_d      = S_BLEND;
			end
			S_BLEND: begin
				cmd.smooth_upd = 1'b1;
				state_d        = S_MUL_SCALE;
			end
			S_MUL_SCALE: begin
				cmd.mul_sel = MUL_SCALE;
				state_d     = S_ACCUM;
			end
			S_ACCUM: begin
				cmd.accum = 1'b1;
				state_d   = S_FINISH;
			end
			S_FINISH: begin
				if (sts.div_done && (!out_valid_q || !out_stall)) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ----- rtl/core/frame_time_smoother_core.sv -----
// ----------------------------------------------------------------------------
// frame_time_smoother_core
// Clamped exponential moving average of frame periods, with a scaled delta,
// a wrapping elapsed total and a frame rate per measured period.
//
//   channel  dir  handshake             payload
//   in       in   in_valid / in_stall   period_us
//   out      out  out_valid / out_stall unscaled_delta_us, scaled_delta,
//                                       elapsed_total, frames_per_second
//   cfg      in   cfg_we                cfg_index, cfg_data
//
// An item is taken at transfer, runs the multiply sequence, then waits for the
// one-bit-per-cycle frame rate divider (quotient width 20 at one million ticks
// per second) and a free output register; no new transfer is taken until its
// result is loaded. The blend and scaling share one 32x16 multiplier. Reset
// clears the averaging state and loads the register defaults. A result waits
// in its output register under out_stall while the next item is worked on.
// ----------------------------------------------------------------------------
module frame_time_smoother_core
	import fts_pkg::*;
#(
	parameter int unsigned TICKS_PER_SECOND = TICKS_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [PERIOD_W-1:0]  period_us,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [PERIOD_W-1:0]  unscaled_delta_us,
	output logic [SCALED_W-1:0]  scaled_delta,
	output logic [ELAPSED_W-1:0] elapsed_total,
	output logic [FPS_W-1:0]     frames_per_second
);

	fts_cmd_t cmd;
	fts_sts_t sts;

	// Sequence control and handshakes
	fts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Arithmetic and state
	fts_dp #(
		.TICKS_PER_SECOND (TICKS_PER_SECOND)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.period_us         (period_us),
		.cmd               (cmd),
		.sts               (sts),
		.unscaled_delta_us (unscaled_delta_us),
		.scaled_delta      (scaled_delta),
		.elapsed_total     (elapsed_total),
		.frames_per_second (frames_per_second)
	);

endmodule

// ----- rtl/core/fts_chk.sv -----
// ----------------------------------------------------------------------------
// fts_chk
// Port-level checks on the frame time smoother, bound to the top level.
// ----------------------------------------------------------------------------
`include "frame_time_smoother_core_assert.svh"

module fts_chk
	import fts_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [PERIOD_W-1:0]  unscaled_delta_us,
	input logic [ELAPSED_W-1:0] elapsed_total,
	input logic [FPS_W-1:0]     frames_per_second
);

	// One item at a time: a transfer closes the input until it is done
	`FTS_ASSERT_NEXT(a_busy_after_transfer, in_valid && !in_stall, in_stall)

	// A zero period always reports a zero frame rate
	`FTS_ASSERT_SAME(a_zero_period_rate, out_valid && (unscaled_delta_us == '0), frames_per_second == '0)

	// A stalled result stays offered
	`FTS_ASSERT_NEXT(a_out_held, out_valid && out_stall, out_valid)

	// A stalled elapsed total does not move
	`FTS_ASSERT_NEXT(a_total_held, out_valid && out_stall, $stable(elapsed_total))

endmodule

bind frame_time_smoother_core fts_chk u_chk (
	.clk               (clk),
	.arst_n            (arst_n),
	.in_valid          (in_valid),
	.in_stall          (in_stall),
	.out_valid         (out_valid),
	.out_stall         (out_stall),
	.unscaled_delta_us (unscaled_delta_us),
	.elapsed_total     (elapsed_total),
	.frames_per_second (frames_per_second)
);

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for frame_time_smoother_core. A queue-fed driver offers
// frame periods, a monitor predicts each result (clamp, moving average, scaled
// delta, elapsed total, frame rate) and checks every output transfer in order.
// Phases sweep register settings and idling mixes, with one long output
// hold-off.
// ----------------------------------------------------------------------------
module testbench;
	import fts_pkg::*;

	localparam int unsigned TICKS     = TICKS_DEFAULT;
	localparam int unsigned CYCLE_CAP = 1000000;
	localparam int unsigned PHASES    = 12;
	localparam int unsigned PHASE_LEN = 103;
	localparam int unsigned HOLD_LEN  = 400;
	localparam int unsigned SETTLE    = 64;

	typedef struct packed {
		logic [PERIOD_W-1:0]  unscaled;
		logic [SCALED_W-1:0]  scaled;
		logic [ELAPSED_W-1:0] elapsed;
		logic [FPS_W-1:0]     fps;
	} frame_result_t;

	logic                 clk;
	logic                 arst_n            = 1'b0;
	logic                 cfg_we            = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index         = CFG_MAX_PERIOD;
	logic [CFG_DAT_W-1:0] cfg_data          = '0;
	logic                 in_valid          = 1'b0;
	logic                 in_stall;
	logic [PERIOD_W-1:0]  period_us         = '0;
	logic                 out_valid;
	logic                 out_stall         = 1'b0;
	logic [PERIOD_W-1:0]  unscaled_delta_us;
	logic [SCALED_W-1:0]  scaled_delta;
	logic [ELAPSED_W-1:0] elapsed_total;
	logic [FPS_W-1:0]     frames_per_second;

	// Register copies and averaging state of the predictor
	logic [PERIOD_W-1:0]  max_period_q = MAX_PERIOD_RST;
	logic [ALPHA_W-1:0]   alpha_q      = ALPHA_RST;
	logic [SCALE_W-1:0]   scale_q      = SCALE_RST;
	logic [SMOOTH_W-1:0]  smooth_q     = '0;
	logic [ELAPSED_W-1:0] elapsed_q    = '0;

	logic [PERIOD_W-1:0] pending_periods[$];
	frame_result_t       expected_frames[$];
	frame_result_t       head_frame;

	logic        in_taken       = 1'b0;
	int unsigned send_idle_pct  = 0;
	int unsigned stall_pct      = 0;
	int unsigned hold_left      = 0;
	int unsigned fail_count     = 0;
	int unsigned periods_sent   = 0;
	int unsigned results_seen   = 0;
	int unsigned settings_count = 0;
	int unsigned cycle_count    = 0;

	frame_time_smoother_core #(
		.TICKS_PER_SECOND(TICKS)
	) uut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.period_us         (period_us),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.unscaled_delta_us (unscaled_delta_us),
		.scaled_delta      (scaled_delta),
		.elapsed_total     (elapsed_total),
		.frames_per_second (frames_per_second)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Advance the averaging state by one frame and return the result it yields
	function automatic frame_result_t smooth_frame(input logic [PERIOD_W-1:0] period);
		logic [63:0]   clamped;
		logic [63:0]   weight;
		logic [63:0]   prev;
		logic [63:0]   blend;
		logic [63:0]   scaled;
		logic [63:0]   rate;
		frame_result_t r;
		clamped = 64'(period);
		if (clamped > 64'(max_period_q))
			clamped = 64'(max_period_q);
		weight = 64'(alpha_q);
		if (weight > 64'(ALPHA_ONE))
			weight = 64'(ALPHA_ONE);
		prev = 64'(smooth_q);
		if (prev == 0) begin
			blend = clamped << 8;
		end else begin
			blend = ((64'd256 - weight) * prev + weight * (clamped << 8)) >> 8;
		end
		smooth_q = blend[SMOOTH_W-1:0];
		scaled = (64'(smooth_q) * 64'(scale_q)) >> 8;
		if (scaled > (64'd1 << SCALED_W) - 1)
			scaled = (64'd1 << SCALED_W) - 1;
		elapsed_q = elapsed_q + ELAPSED_W'(scaled[SCALED_W-1:0]);
		rate = (clamped == 0) ? 64'd0 : 64'(TICKS) / clamped;
		if (rate > 64'(FPS_MAX))
			rate = 64'(FPS_MAX);
		r.unscaled = clamped[PERIOD_W-1:0];
		r.scaled   = scaled[SCALED_W-1:0];
		r.elapsed  = elapsed_q;
		r.fps      = rate[FPS_W-1:0];
		return r;
	endfunction

	// Mix of zero, tiny, typical, near-clamp and full-range periods
	function automatic logic [PERIOD_W-1:0] pick_period();
		logic [PERIOD_W+1:0] near;
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return PERIOD_W'($urandom_range(64, 1));
			3, 4: return PERIOD_W'($urandom_range(60000, 4000));
			5: begin
				near = {2'b00, max_period_q} + (PERIOD_W+2)'($urandom_range(4));
				if (near >= (PERIOD_W+2)'(2))
					near = near - (PERIOD_W+2)'(2);
				if (near > {2'b00, {PERIOD_W{1'b1}}})
					near = {2'b00, {PERIOD_W{1'b1}}};
				return near[PERIOD_W-1:0];
			end
			default: return PERIOD_W'($urandom);
		endcase
	endfunction

	task automatic compare_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	// Write one register and mirror it into the predictor
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_MAX_PERIOD: max_period_q = data[PERIOD_W-1:0];
			CFG_ALPHA: alpha_q = data[ALPHA_W-1:0];
			CFG_SCALE: scale_q = data[SCALE_W-1:0];
			default: ;
		endcase
	endtask

	// Load all three registers; unused upper data bits carry noise
	task automatic set_regs(input logic [PERIOD_W-1:0] max_v, input logic [ALPHA_W-1:0] alpha_v,
			input logic [SCALE_W-1:0] scale_v);
		logic [CFG_DAT_W-1:0] data;
		write_reg(CFG_MAX_PERIOD, max_v);
		data = CFG_DAT_W'($urandom);
		data[ALPHA_W-1:0] = alpha_v;
		write_reg(CFG_ALPHA, data);
		data = CFG_DAT_W'($urandom);
		data[SCALE_W-1:0] = scale_v;
		write_reg(CFG_SCALE, data);
		settings_count++;
	endtask

	// Hold until every queued period is taken and every result is back
	task automatic drain();
		while (pending_periods.size() > 0 || expected_frames.size() > 0)
			@(posedge clk);
	endtask

	// Drive input transfers and output stalls on the falling edge
	always @(negedge clk) begin
		if (!in_valid || in_taken) begin
			if (pending_periods.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid  <= 1'b1;
				period_us <= pending_periods[0];
			end else begin
				in_valid  <= 1'b0;
				period_us <= PERIOD_W'($urandom);
			end
		end
		in_taken = 1'b0;
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Check output transfers, then predict for input transfers
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (expected_frames.size() == 0) begin
					$error("result transfer with no frame outstanding");
					fail_count++;
				end else begin
					head_frame = expected_frames.pop_front();
					compare_field("unscaled_delta_us", 64'(head_frame.unscaled),
						64'(unscaled_delta_us));
					compare_field("scaled_delta", 64'(head_frame.scaled), 64'(scaled_delta));
					compare_field("elapsed_total", 64'(head_frame.elapsed), 64'(elapsed_total));
					compare_field("frames_per_second", 64'(head_frame.fps),
						64'(frames_per_second));
				end
			end
			if (in_valid && !in_stall) begin
				expected_frames.push_back(smooth_frame(period_us));
				void'(pending_periods.pop_front());
				in_taken = 1'b1;
				periods_sent++;
			end
		end
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_CAP) begin
			$display("timeout after %0d cycles, %0d frames outstanding", cycle_count,
				expected_frames.size());
			$display("** frame_time_smoother_core: FAILED **");
			$finish;
		end
	end

	initial begin
		int unsigned         ph;
		int unsigned         n;
		logic [PERIOD_W-1:0] max_v;
		logic [ALPHA_W-1:0]  alpha_v;
		logic [SCALE_W-1:0]  scale_v;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset defaults: zero periods keep the average at zero, then load and clamp
		pending_periods = '{24'd0, 24'd0, 24'd1, 24'd2, 24'd16667, 24'd100000, 24'd100001,
			24'hFFFFFF, 24'd33333};
		drain();

		// Widest clamp, alpha above one, full scale
		set_regs('1, 9'd511, 16'hFFFF);
		pending_periods = '{24'hFFFFFF, 24'd1, 24'd0, 24'hFFFFFF};
		drain();

		// Alpha zero freezes a nonzero average
		set_regs(24'd1, 9'd0, 16'd1);
		pending_periods = '{24'd5, 24'd1, 24'd0};
		drain();

		// Zero clamp forces every period to zero
		set_regs(24'd0, 9'd128, 16'd256);
		pending_periods = '{24'd123, 24'hFFFFFF};
		drain();

		for (ph = 0; ph < PHASES; ph++) begin
			// Pick register settings, extremes first
			case (ph)
				0: set_regs('1, ALPHA_ONE, 16'hFFFF);
				1: set_regs(24'd1, 9'd1, 16'd0);
				2: set_regs(MAX_PERIOD_RST, ALPHA_RST, SCALE_RST);
				3: set_regs(24'd50, 9'd257, 16'd1);
				default: begin
					case ($urandom_range(4))
						0: max_v = PERIOD_W'($urandom_range(255, 1));
						1: max_v = PERIOD_W'($urandom_range(200000, 1000));
						2: max_v = PERIOD_W'($urandom);
						3: max_v = '1;
						default: max_v = '0;
					endcase
					case ($urandom_range(4))
						0: alpha_v = ALPHA_W'($urandom_range(256, 1));
						1: alpha_v = ALPHA_W'($urandom_range(64, 1));
						2: alpha_v = ALPHA_W'($urandom_range(511, 257));
						3: alpha_v = '0;
						default: alpha_v = ALPHA_ONE;
					endcase
					case ($urandom_range(3))
						0: scale_v = SCALE_W'($urandom);
						1: scale_v = SCALE_W'($urandom_range(512, 0));
						2: scale_v = '1;
						default: scale_v = '0;
					endcase
					set_regs(max_v, alpha_v, scale_v);
				end
			endcase

			// Rotate through idling mixes
			case (ph % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct     = 0;
				end
				1: begin
					send_idle_pct = 51;
					stall_pct     = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct     = 51;
				end
				default: begin
					send_idle_pct = 27;
					stall_pct     = 27;
				end
			endcase

			for (n = 0; n < PHASE_LEN; n++)
				pending_periods.push_back(pick_period());

			// Block the output for a long stretch while the sender keeps offering
			if (ph == 6) begin
				while (expected_frames.size() == 0)
					@(posedge clk);
				hold_left = HOLD_LEN;
			end
			drain();
		end

		repeat (SETTLE) @(posedge clk);

		$display("Sent %0d frame periods and checked %0d results across %0d register settings,",
			periods_sent, results_seen, settings_count);
		$display("with clamp, alpha and scale extremes, four idling mixes and a long output stall.");
		if (fail_count == 0) begin
			$display("** frame_time_smoother_core: PASSED **");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("** frame_time_smoother_core: FAILED **");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/fts_pkg.sv
rtl/core/fts_div.sv
rtl/core/fts_dp.sv
rtl/core/fts_ctrl.sv
rtl/core/frame_time_smoother_core.sv
rtl/core/fts_chk.sv
verif/testbench.sv
